// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/wwa_pkg.sv =====
// shared types and constants for the worker wakeup arbiter
`timescale 1ns / 1ps
package wwa_pkg;
	localparam int MAX_WORKERS = 64;
	localparam int CNT_W = 7;

	// event codes
	localparam logic [2:0] MODE_TRY_SPIN    = 3'd0;
	localparam logic [2:0] MODE_STOP_SPIN   = 3'd1;
	localparam logic [2:0] MODE_ENTER_SLEEP = 3'd2;
	localparam logic [2:0] MODE_LEAVE_SLEEP = 3'd3;
	localparam logic [2:0] MODE_WAKE_ONE    = 3'd4;
	localparam logic [2:0] MODE_WAKE_N      = 3'd5;

	// configuration register indexes
	localparam logic CFG_POOL_SIZE    = 1'b0;
	localparam logic CFG_MAX_SPINNERS = 1'b1;

	// reset values of the configuration registers
	localparam logic [6:0] POOL_SIZE_RST    = 7'd64;
	localparam logic [6:0] MAX_SPINNERS_RST = 7'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
		logic step;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_clear;
		logic last_step;
	} dp_status_t;
endpackage

// ===== rtl/wwa_dp.sv =====
// datapath: worker masks, counts, event evaluation and result registers
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wwa_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wwa_pkg::ctrl_cmd_t    cmd,
	output wwa_pkg::dp_status_t   status,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [6:0]            cfg_data,
	input  logic [2:0]            mode,
	input  logic [5:0]            worker,
	input  logic [15:0]           count,
	output logic                  success,
	output logic [63:0]           spinners_claimed,
	output logic [63:0]           sleepers_woken,
	output logic [63:0]           spinning_now,
	output logic [63:0]           sleeping_now
);
	import wwa_pkg::*;

	logic [6:0]       pool_size_q, max_spinners_q;
	logic [2:0]       mode_q;
	logic [5:0]       worker_q;
	logic [15:0]      count_q;
	logic [63:0]      spin_q, sleep_q, claimed_q, woken_q;
	logic [CNT_W-1:0] spin_cnt_q, sleep_cnt_q, left_q;
	logic             success_q;

	logic [63:0]      spin_d, sleep_d, claimed_d, woken_d;
	logic [CNT_W-1:0] spin_cnt_d, sleep_cnt_d, left_d;
	logic             success_d, need_clear, wake_one_en;
	logic [63:0]      wbit, spin_low, sleep_low;
	logic [6:0]       gs_eff;
	logic [15:0]      remain;
	logic             wvalid, spin_hit, sleep_hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q    <= POOL_SIZE_RST;
			max_spinners_q <= MAX_SPINNERS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POOL_SIZE:    pool_size_q    <= cfg_data;
				CFG_MAX_SPINNERS: max_spinners_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			worker_q <= worker;
			count_q  <= count;
		end
	end

	// shared decode terms
	assign gs_eff    = (pool_size_q > 7'(MAX_WORKERS)) ? 7'(MAX_WORKERS) : pool_size_q;
	assign wvalid    = {1'b0, worker_q} < gs_eff;
	assign wbit      = 64'd1 << worker_q;
	assign spin_hit  = |(spin_q & wbit);
	assign sleep_hit = |(sleep_q & wbit);
	assign spin_low  = spin_q & (~spin_q + 64'd1);
	assign sleep_low = sleep_q & (~sleep_q + 64'd1);
	// wake count left for sleepers once all spinners are claimed
	assign remain    = (count_q > {9'd0, spin_cnt_q}) ? count_q - {9'd0, spin_cnt_q} : 16'd0;

	// event evaluation and lowest-sleeper clearing
	always_comb begin
		spin_d      = spin_q;
		sleep_d     = sleep_q;
		spin_cnt_d  = spin_cnt_q;
		sleep_cnt_d = sleep_cnt_q;
		claimed_d   = claimed_q;
		woken_d     = woken_q;
		success_d   = success_q;
		left_d      = left_q;
		need_clear  = 1'b0;
		wake_one_en = 1'b0;
		if (cmd.exec) begin
			success_d = 1'b0;
			claimed_d = '0;
			woken_d   = '0;
			case (mode_q)
				MODE_TRY_SPIN: begin
					if (wvalid && (spin_cnt_q < max_spinners_q)) begin
						spin_d    = spin_q | wbit;
						success_d = 1'b1;
						if (!spin_hit) spin_cnt_d = spin_cnt_q + 7'd1;
					end
				end
				MODE_STOP_SPIN: begin
					if (wvalid) begin
						success_d = spin_hit;
						spin_d    = spin_q & ~wbit;
						if (spin_hit) spin_cnt_d = spin_cnt_q - 7'd1;
					end
				end
				MODE_ENTER_SLEEP: begin
					if (wvalid) begin
						sleep_d   = sleep_q | wbit;
						success_d = 1'b1;
						if (!sleep_hit) sleep_cnt_d = sleep_cnt_q + 7'd1;
					end
				end
				MODE_LEAVE_SLEEP: begin
					if (wvalid) begin
						success_d = sleep_hit;
						sleep_d   = sleep_q & ~wbit;
						if (sleep_hit) sleep_cnt_d = sleep_cnt_q - 7'd1;
					end
				end
				MODE_WAKE_ONE: wake_one_en = 1'b1;
				MODE_WAKE_N: begin
					if (count_q == 16'd1) begin
						wake_one_en = 1'b1;
					end else if (count_q >= 16'd2) begin
						claimed_d  = spin_q;
						spin_d     = '0;
						spin_cnt_d = '0;
						if ((remain >= {9'd0, gs_eff}) ||
						    ((remain != 16'd0) && ({9'd0, sleep_cnt_q} <= remain))) begin
							woken_d     = sleep_q;
							sleep_d     = '0;
							sleep_cnt_d = '0;
							success_d   = |(spin_q | sleep_q);
						end else if (remain != 16'd0) begin
							// fewer than all sleepers: clear them one per cycle
							need_clear = 1'b1;
							left_d     = remain[CNT_W-1:0];
							success_d  = 1'b1;
						end else begin
							success_d = |spin_q;
						end
					end
				end
				default: ;
			endcase
			// lowest spinner, else lowest sleeper
			if (wake_one_en) begin
				if (spin_q != '0) begin
					claimed_d  = spin_low;
					spin_d     = spin_q & ~spin_low;
					spin_cnt_d = spin_cnt_q - 7'd1;
					success_d  = 1'b1;
				end else if (sleep_q != '0) begin
					woken_d     = sleep_low;
					sleep_d     = sleep_q & ~sleep_low;
					sleep_cnt_d = sleep_cnt_q - 7'd1;
					success_d   = 1'b1;
				end
			end
		end else if (cmd.step) begin
			woken_d     = woken_q | sleep_low;
			sleep_d     = sleep_q & ~sleep_low;
			sleep_cnt_d = sleep_cnt_q - 7'd1;
			left_d      = left_q - 7'd1;
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q      <= '0;
			sleep_q     <= '0;
			spin_cnt_q  <= '0;
			sleep_cnt_q <= '0;
			claimed_q   <= '0;
			woken_q     <= '0;
			success_q   <= 1'b0;
			left_q      <= '0;
		end else begin
			spin_q      <= spin_d;
			sleep_q     <= sleep_d;
			spin_cnt_q  <= spin_cnt_d;
			sleep_cnt_q <= sleep_cnt_d;
			claimed_q   <= claimed_d;
			woken_q     <= woken_d;
			success_q   <= success_d;
			left_q      <= left_d;
		end
	end

	assign status.need_clear = need_clear;
	assign status.last_step  = (left_q == 7'd1);

	assign success          = success_q;
	assign spinners_claimed = claimed_q;
	assign sleepers_woken   = woken_q;
	assign spinning_now     = spin_q;
	assign sleeping_now     = sleep_q;

	// counts track the masks
	`ASSERT_PROP(a_spin_cnt, clk, arst_n, ($countones(spin_q) == 32'(spin_cnt_q)))
	`ASSERT_PROP(a_sleep_cnt, clk, arst_n, ($countones(sleep_q) == 32'(sleep_cnt_q)))
	// claimed workers are gone from their masks
	`ASSERT_NEVER(a_claim_gone, clk, arst_n, ((claimed_q & spin_q) != '0))
	`ASSERT_NEVER(a_woken_gone, clk, arst_n, ((woken_q & sleep_q) != '0))
endmodule

// ===== rtl/wwa_ctrl.sv =====
// controller: sequences load, evaluate, clear steps and result handshake
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wwa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wwa_pkg::ctrl_cmd_t   cmd,
	input  wwa_pkg::dp_status_t  status
);
	import wwa_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_CLEAR = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC:  state_d = status.need_clear ? ST_CLEAR : ST_DONE;
			ST_CLEAR: if (status.last_step) state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// handshake and datapath commands
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign cmd.load  = in_ready && in_valid;
	assign cmd.exec  = (state_q == ST_EXEC);
	assign cmd.step  = (state_q == ST_CLEAR);

	// one request in flight at a time
	`ASSERT_NEVER(a_excl, clk, arst_n, (in_ready && out_valid))
	// an accepted request is always evaluated next
	`ASSERT_PROP(a_load_exec, clk, arst_n, (cmd.load |=> cmd.exec))
	// clearing only follows evaluation or another clear step
	`ASSERT_PROP(a_clear_src, clk, arst_n, ($rose(cmd.step) |-> $past(cmd.exec)))
endmodule

// ===== rtl/worker_wakeup_arbiter.sv =====
// Sequence: an accepted request is evaluated in the EXEC state and out_valid rises in DONE;
// a wake_n that wakes only part of the sleepers first passes through CLEAR, which wakes them
// one by one (up to 63), using the single lowest-set-bit clear unit in the datapath.
// Flow: one request in flight; the next is accepted the cycle after the result is taken.
// Reset: both worker masks clear, pool size 64, max_spinners 2, no clearing pass.
`timescale 1ns / 1ps
module worker_wakeup_arbiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [5:0]  worker,
	input  logic [15:0] count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        success,
	output logic [63:0] spinners_claimed,
	output logic [63:0] sleepers_woken,
	output logic [63:0] spinning_now,
	output logic [63:0] sleeping_now
);
	import wwa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencing
	wwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// masks and results
	wwa_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mode             (mode),
		.worker           (worker),
		.count            (count),
		.success          (success),
		.spinners_claimed (spinners_claimed),
		.sleepers_woken   (sleepers_woken),
		.spinning_now     (spinning_now),
		.sleeping_now     (sleeping_now)
	);
endmodule

// ===== verif/tb_worker_wakeup_arbiter.sv =====
// testbench for the worker wakeup arbiter: directed and random requests, scoreboard check
`timescale 1ns / 1ps
module tb_worker_wakeup_arbiter;
	import wwa_pkg::*;

	// modes the block must ignore
	localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 36;

	// predicted state of both worker masks and the expected results in order
	class wakeup_scoreboard;
		typedef struct {
			bit        success;
			bit [63:0] claimed;
			bit [63:0] woken;
			bit [63:0] spinning;
			bit [63:0] sleeping;
		} wake_result_t;

		bit [6:0]     pool_size;
		bit [6:0]     max_spinners;
		bit [63:0]    spin_mask;
		bit [63:0]    sleep_mask;
		wake_result_t expected_results[$];
		int           errors;

		function new();
			pool_size = POOL_SIZE_RST;
			max_spinners = MAX_SPINNERS_RST;
			spin_mask = '0;
			sleep_mask = '0;
			errors = 0;
		endfunction

		function void write_reg(logic index, bit [6:0] value);
			if (index == CFG_POOL_SIZE) begin
				pool_size = value;
			end else begin
				max_spinners = value;
			end
		endfunction

		function int active_size();
			return (pool_size < MAX_WORKERS) ? int'(pool_size) : MAX_WORKERS;
		endfunction

		// lowest spinner first, else lowest sleeper
		function void claim_lowest(inout wake_result_t r);
			if (spin_mask != 0) begin
				r.claimed = spin_mask & (~spin_mask + 64'd1);
				spin_mask &= ~r.claimed;
				r.success = 1'b1;
			end else if (sleep_mask != 0) begin
				r.woken = sleep_mask & (~sleep_mask + 64'd1);
				sleep_mask &= ~r.woken;
				r.success = 1'b1;
			end
		endfunction

		function void note_request(bit [2:0] m, bit [5:0] w, bit [15:0] c);
			wake_result_t r;
			int           size;
			int           took;
			int           n;
			bit [63:0]    wbit;
			bit [63:0]    rest;
			size = active_size();
			wbit = 64'd1 << w;
			r.success = 1'b0;
			r.claimed = '0;
			r.woken = '0;
			case (m)
				MODE_TRY_SPIN: begin
					if (w < size && $countones(spin_mask) < max_spinners) begin
						spin_mask |= wbit;
						r.success = 1'b1;
					end
				end
				MODE_STOP_SPIN: begin
					if (w < size) begin
						r.success = (spin_mask & wbit) != 0;
						spin_mask &= ~wbit;
					end
				end
				MODE_ENTER_SLEEP: begin
					if (w < size) begin
						sleep_mask |= wbit;
						r.success = 1'b1;
					end
				end
				MODE_LEAVE_SLEEP: begin
					if (w < size) begin
						r.success = (sleep_mask & wbit) != 0;
						sleep_mask &= ~wbit;
					end
				end
				MODE_WAKE_ONE: begin
					claim_lowest(r);
				end
				MODE_WAKE_N: begin
					if (c == 1) begin
						claim_lowest(r);
					end else if (c >= 2) begin
						// every spinner goes first, the rest of the count falls to sleepers
						r.claimed = spin_mask;
						spin_mask = '0;
						took = $countones(r.claimed);
						n = (c > took) ? int'(c) - took : 0;
						if (n >= size || (n >= 1 && $countones(sleep_mask) <= n)) begin
							r.woken = sleep_mask;
							sleep_mask = '0;
						end else if (n >= 1) begin
							rest = sleep_mask;
							while (n != 0 && rest != 0) begin
								rest &= rest - 64'd1;
								n--;
							end
							r.woken = sleep_mask & ~rest;
							sleep_mask = rest;
						end
						r.success = (r.claimed | r.woken) != 0;
					end
				end
				default: ;
			endcase
			r.spinning = spin_mask;
			r.sleeping = sleep_mask;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, bit [63:0] exp_v, logic [63:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(logic s, logic [63:0] cl, logic [63:0] wo,
				logic [63:0] sp, logic [63:0] sl);
			wake_result_t e;
			if (expected_results.size() == 0) begin
				$error("result seen with no request outstanding");
				errors++;
				return;
			end
			e = expected_results.pop_front();
			compare_field("success", 64'(e.success), 64'(s));
			compare_field("spinners_claimed", e.claimed, cl);
			compare_field("sleepers_woken", e.woken, wo);
			compare_field("spinning_now", e.spinning, sp);
			compare_field("sleeping_now", e.sleeping, sl);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = '0;
	logic [5:0]  worker = '0;
	logic [15:0] count = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        success;
	logic [63:0] spinners_claimed;
	logic [63:0] sleepers_woken;
	logic [63:0] spinning_now;
	logic [63:0] sleeping_now;

	bit               steady = 1'b0;
	int               cycle_count = 0;
	wakeup_scoreboard board;

	worker_wakeup_arbiter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.mode             (mode),
		.worker           (worker),
		.count            (count),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.success          (success),
		.spinners_claimed (spinners_claimed),
		.sleepers_woken   (sleepers_woken),
		.spinning_now     (spinning_now),
		.sleeping_now     (sleeping_now)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// random backpressure on the result side
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(success, spinners_claimed, sleepers_woken,
				spinning_now, sleeping_now);
		end
	end

	// present one request and hold it until accepted; valid stays up for the caller
	task automatic send_request(logic [2:0] m, logic [5:0] w, logic [15:0] c);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		worker <= w;
		count <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_request(m, w, c);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers while the block is idle
	task automatic reconfigure(logic [6:0] gs, logic [6:0] ms);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_POOL_SIZE;
		cfg_data <= gs;
		board.write_reg(CFG_POOL_SIZE, gs);
		@(posedge clk);
		cfg_index <= CFG_MAX_SPINNERS;
		cfg_data <= ms;
		board.write_reg(CFG_MAX_SPINNERS, ms);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// random requests weighted toward building up and waking worker masks
	task automatic run_random(int items);
		int          pick;
		int          size;
		bit [63:0]   mask;
		logic [2:0]  m;
		logic [5:0]  w;
		logic [15:0] c;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			if (pick < 20) m = MODE_TRY_SPIN;
			else if (pick < 30) m = MODE_STOP_SPIN;
			else if (pick < 58) m = MODE_ENTER_SLEEP;
			else if (pick < 68) m = MODE_LEAVE_SLEEP;
			else if (pick < 78) m = MODE_WAKE_ONE;
			else if (pick < 95) m = MODE_WAKE_N;
			else if (pick < 98) m = MODE_UNUSED_LO;
			else m = MODE_UNUSED_HI;

			size = board.active_size();
			if (size > 0 && $urandom_range(99) < 85) begin
				w = 6'($urandom_range(size - 1, 0));
			end else begin
				w = 6'($urandom_range(63, 0));
			end
			// stop and leave mostly target a worker whose bit is set
			mask = (m == MODE_STOP_SPIN) ? board.spin_mask : board.sleep_mask;
			if ((m == MODE_STOP_SPIN || m == MODE_LEAVE_SLEEP) && mask != 0 &&
					$urandom_range(99) < 60) begin
				while (!mask[w]) w = w + 6'd1;
			end

			pick = $urandom_range(99);
			if (pick < 50) c = 16'($urandom_range(4, 0));
			else if (pick < 75) c = 16'($urandom_range(70, 0));
			else c = 16'($urandom_range(65535, 0));

			if ($urandom_range(99) < 2) drain_results();
			send_request(m, w, c);
		end
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: group of 64, two spinners
		send_request(MODE_TRY_SPIN, 6'd0, 16'd0);
		send_request(MODE_TRY_SPIN, 6'd63, 16'hffff);
		send_request(MODE_TRY_SPIN, 6'd5, 16'd0);
		send_request(MODE_TRY_SPIN, 6'd0, 16'd0);
		send_request(MODE_STOP_SPIN, 6'd63, 16'd0);
		send_request(MODE_STOP_SPIN, 6'd63, 16'd0);
		send_request(MODE_ENTER_SLEEP, 6'd63, 16'd0);
		send_request(MODE_ENTER_SLEEP, 6'd1, 16'd0);
		send_request(MODE_ENTER_SLEEP, 6'd2, 16'd0);
		send_request(MODE_ENTER_SLEEP, 6'd40, 16'd0);
		send_request(MODE_LEAVE_SLEEP, 6'd40, 16'd0);
		send_request(MODE_LEAVE_SLEEP, 6'd40, 16'd0);
		send_request(MODE_WAKE_N, 6'd0, 16'd0);
		send_request(MODE_WAKE_ONE, 6'd0, 16'd0);
		send_request(MODE_WAKE_ONE, 6'd0, 16'd0);
		send_request(MODE_TRY_SPIN, 6'd3, 16'd0);
		send_request(MODE_TRY_SPIN, 6'd4, 16'd0);
		send_request(MODE_WAKE_N, 6'd0, 16'd1);
		// one spinner, partial sleeper wake
		send_request(MODE_WAKE_N, 6'd0, 16'd2);
		// as many spinners as the count leaves nothing for sleepers
		send_request(MODE_TRY_SPIN, 6'd7, 16'd0);
		send_request(MODE_TRY_SPIN, 6'd8, 16'd0);
		send_request(MODE_WAKE_N, 6'd0, 16'd2);
		send_request(MODE_WAKE_N, 6'd0, 16'hffff);
		send_request(MODE_WAKE_ONE, 6'd0, 16'd0);
		send_request(MODE_UNUSED_LO, 6'd63, 16'hffff);
		send_request(MODE_UNUSED_HI, 6'd0, 16'd0);

		// small group: out-of-range workers are refused
		reconfigure(7'd8, 7'd3);
		send_request(MODE_TRY_SPIN, 6'd8, 16'd0);
		send_request(MODE_ENTER_SLEEP, 6'd63, 16'd0);
		send_request(MODE_LEAVE_SLEEP, 6'd9, 16'd0);
		run_random(60);

		// empty group, spinning disabled
		reconfigure(7'd0, 7'd0);
		send_request(MODE_TRY_SPIN, 6'd0, 16'd0);
		send_request(MODE_WAKE_N, 6'd0, 16'd2);
		run_random(30);

		reconfigure(7'd1, 7'd1);
		run_random(30);

		// top register values with no idling on either side
		reconfigure(7'd127, 7'd127);
		steady = 1'b1;
		run_random(80);
		drain_results();
		steady = 1'b0;

		reconfigure(7'd64, 7'd64);
		run_random(60);
		reconfigure(7'd37, 7'd5);
		run_random(60);
		reconfigure(7'd64, 7'd2);
		run_random(80);

		drain_results();
		repeat (70) @(posedge clk);
		if (board.errors == 0 && board.expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ===== worker_wakeup_arbiter.f =====
+incdir+rtl
rtl/wwa_pkg.sv
rtl/wwa_dp.sv
rtl/wwa_ctrl.sv
rtl/worker_wakeup_arbiter.sv
verif/tb_worker_wakeup_arbiter.sv
